### src/bfea_pkg.sv
// Shared types and codes for the best-fit extent allocator.
`default_nettype none

package bfea_pkg;

	localparam int FIELD_W   = 32;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_FREE    = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_OOM      = 3'd1,
		ST_OVERLAP  = 3'd2,
		ST_FULL     = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REGION_START = 1'd0,
		REG_REGION_END   = 1'd1
	} cfg_reg_t;

	// Control from the sequencer to the scan unit.
	typedef struct packed {
		logic clr;
		logic en;
		logic is_free;
	} scan_ctl_t;

	// What one pass over the table found.
	typedef struct packed {
		logic best;
		logic overlap;
		logic left;
		logic right;
		logic slot;
	} scan_flags_t;

endpackage

`default_nettype wire

### src/bfea_if.sv
// Request and response channel interfaces of the extent allocator.
`default_nettype none

interface bfea_in_if;
	logic                          valid;
	logic                          ready;
	logic [bfea_pkg::MODE_W-1:0]   mode;
	logic [bfea_pkg::FIELD_W-1:0]  start_block;
	logic [bfea_pkg::FIELD_W-1:0]  block_count;

	modport source (output valid, output mode, output start_block, output block_count,
		input ready);
	modport sink (input valid, input mode, input start_block, input block_count,
		output ready);
endinterface

interface bfea_out_if;
	logic                            valid;
	logic                            ready;
	logic [bfea_pkg::FIELD_W-1:0]    alloc_start;
	logic [bfea_pkg::STATUS_W-1:0]   status;

	modport source (output valid, output alloc_start, output status, input ready);
	modport sink (input valid, input alloc_start, input status, output ready);
endinterface

`default_nettype wire

### src/best_fit_extent_allocator.sv
// Top level of the best-fit extent allocator: sequencer, config registers, result register.
//
//  channel  | role   | handshake   | payload
//  ---------+--------+-------------+-------------------------------------
//  in_ch    | sink   | valid/ready | mode, start_block, block_count
//  out_ch   | source | valid/ready | alloc_start, status
//  cfg      | write  | cfg_we      | cfg_index, cfg_data
//
// Allocate and free scan the whole table through the single read port of the extent
// memory, one entry per cycle; the scan is followed by the drain, decide and result states,
// with a second write state when a free merges both neighbors, and then the sequencer is idle.
// Restart sweeps the table, writing every entry, and then goes to the result state.
// A refused free range or the unused mode goes straight from accept to the result state.
// After reset a clearing pass over every entry runs before the first item is taken.
// The next item is taken while a result waits in the output register; a stalled output
// holds the sequencer only when a second result is ready.
`default_nettype none

module best_fit_extent_allocator #(
	parameter int MAX_EXTENTS = 64,
	parameter int BLOCK_BITS  = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bfea_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bfea_pkg::FIELD_W-1:0]     cfg_data,
	bfea_in_if.sink                               in_ch,
	bfea_out_if.source                            out_ch
);

	localparam int IDX_W = $clog2(MAX_EXTENTS);
	localparam int ENT_W = 2 * BLOCK_BITS + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_EXTENTS - 1);

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_WRITE2,
		S_RESULT
	} state_t;

	state_t                      state_q;
	logic [IDX_W-1:0]            cnt_q;
	logic                        init_q;
	logic [BLOCK_BITS-1:0]       region_start_q;
	logic [BLOCK_BITS-1:0]       region_end_q;
	bfea_pkg::mode_t             req_mode_q;
	logic [BLOCK_BITS-1:0]       req_start_q;
	logic [BLOCK_BITS-1:0]       req_count_q;
	logic [BLOCK_BITS-1:0]       req_end_q;
	bfea_pkg::status_t           res_status_q;
	logic [BLOCK_BITS-1:0]       res_where_q;
	logic                        out_valid_q;
	logic [bfea_pkg::FIELD_W-1:0] out_start_q;
	bfea_pkg::status_t           out_status_q;
	logic                        rd_vld_s1;
	logic [IDX_W-1:0]            rd_idx_s1;

	logic                        in_acc;
	logic [BLOCK_BITS:0]         in_sum;
	logic                        in_ovf;
	bfea_pkg::mode_t             in_mode;

	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	logic [ENT_W-1:0]            mem_wdata;
	logic                        mem_re;
	logic [ENT_W-1:0]            mem_rdata;

	bfea_pkg::scan_ctl_t         scan_ctl;
	bfea_pkg::scan_flags_t       flags;
	logic [IDX_W-1:0]            best_idx;
	logic [BLOCK_BITS-1:0]       best_start;
	logic [BLOCK_BITS-1:0]       best_end;
	logic [IDX_W-1:0]            left_idx;
	logic [BLOCK_BITS-1:0]       left_start;
	logic [IDX_W-1:0]            right_idx;
	logic [BLOCK_BITS-1:0]       right_end;
	logic [IDX_W-1:0]            slot_idx;

	logic                        dec_we;
	logic [IDX_W-1:0]            dec_addr;
	logic [ENT_W-1:0]            dec_data;
	bfea_pkg::status_t           dec_status;
	logic [BLOCK_BITS-1:0]       dec_where;
	logic                        dec_two;
	logic [BLOCK_BITS-1:0]       alloc_next;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign in_mode     = bfea_pkg::mode_t'(in_ch.mode);
	assign in_sum      = {1'b0, in_ch.start_block[BLOCK_BITS-1:0]} +
		{1'b0, in_ch.block_count[BLOCK_BITS-1:0]};
	// A freed range whose end does not fit the block width is refused.
	assign in_ovf      = in_sum[BLOCK_BITS];

	assign out_ch.valid       = out_valid_q;
	assign out_ch.alloc_start = out_start_q;
	assign out_ch.status      = out_status_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			region_end_q   <= '0;
		end else if (cfg_we) begin
			unique case (bfea_pkg::cfg_reg_t'(cfg_index))
				bfea_pkg::REG_REGION_START: region_start_q <= cfg_data[BLOCK_BITS-1:0];
				bfea_pkg::REG_REGION_END:   region_end_q   <= cfg_data[BLOCK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read pipeline tag: which entry the memory returns this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
	end

	assign scan_ctl.clr     = in_acc;
	assign scan_ctl.en      = rd_vld_s1;
	assign scan_ctl.is_free = (req_mode_q == bfea_pkg::MODE_FREE);

	bfea_mem #(
		.DEPTH (MAX_EXTENTS),
		.WIDTH (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (cnt_q),
		.rdata (mem_rdata)
	);

	bfea_scan #(
		.BLOCK_BITS (BLOCK_BITS),
		.IDX_W      (IDX_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.ent_valid  (mem_rdata[ENT_W-1]),
		.ent_start  (mem_rdata[2*BLOCK_BITS-1:BLOCK_BITS]),
		.ent_end    (mem_rdata[BLOCK_BITS-1:0]),
		.ent_idx    (rd_idx_s1),
		.req_start  (req_start_q),
		.req_end    (req_end_q),
		.req_count  (req_count_q),
		.flags      (flags),
		.best_idx   (best_idx),
		.best_start (best_start),
		.best_end   (best_end),
		.left_idx   (left_idx),
		.left_start (left_start),
		.right_idx  (right_idx),
		.right_end  (right_end),
		.slot_idx   (slot_idx)
	);

	// Outcome of a scan: status, returned start and the first write-back.
	always_comb begin
		alloc_next = best_start + req_count_q;
		dec_we     = 1'b0;
		dec_addr   = best_idx;
		dec_data   = '0;
		dec_status = bfea_pkg::ST_OK;
		dec_where  = '0;
		dec_two    = 1'b0;
		if (req_mode_q == bfea_pkg::MODE_ALLOC) begin
			if (!flags.best) begin
				dec_status = bfea_pkg::ST_OOM;
			end else begin
				// Drop the extent once it is used up.
				dec_we    = 1'b1;
				dec_data  = {alloc_next != best_end, alloc_next, best_end};
				dec_where = best_start;
			end
		end else begin
			priority if (flags.overlap) begin
				dec_status = bfea_pkg::ST_OVERLAP;
			end else if (req_count_q == '0) begin
				dec_status = bfea_pkg::ST_OK;
			end else if (flags.left) begin
				dec_we   = 1'b1;
				dec_addr = left_idx;
				dec_data = {1'b1, left_start, flags.right ? right_end : req_end_q};
				dec_two  = flags.right;
			end else if (flags.right) begin
				dec_we   = 1'b1;
				dec_addr = right_idx;
				dec_data = {1'b1, req_start_q, right_end};
			end else if (flags.slot) begin
				dec_we   = 1'b1;
				dec_addr = slot_idx;
				dec_data = {1'b1, req_start_q, req_end_q};
			end else begin
				dec_status = bfea_pkg::ST_FULL;
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				mem_we = 1'b1;
				if (!init_q && (cnt_q == '0) && (region_end_q > region_start_q)) begin
					mem_wdata = {1'b1, region_start_q, region_end_q};
				end
			end
			S_SCAN: begin
				mem_re = 1'b1;
			end
			S_DECIDE: begin
				mem_we    = dec_we;
				mem_waddr = dec_addr;
				mem_wdata = dec_data;
			end
			S_WRITE2: begin
				// Right neighbor was absorbed into the left one.
				mem_we    = 1'b1;
				mem_waddr = right_idx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			cnt_q        <= '0;
			init_q       <= 1'b1;
			req_mode_q   <= bfea_pkg::MODE_NOP;
			req_start_q  <= '0;
			req_count_q  <= '0;
			req_end_q    <= '0;
			res_status_q <= bfea_pkg::ST_OK;
			res_where_q  <= '0;
			out_valid_q  <= 1'b0;
			out_start_q  <= '0;
			out_status_q <= bfea_pkg::ST_OK;
		end else begin
			if (out_valid_q && out_ch.ready && (state_q != S_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_RESULT;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						req_mode_q   <= in_mode;
						req_start_q  <= in_ch.start_block[BLOCK_BITS-1:0];
						req_count_q  <= in_ch.block_count[BLOCK_BITS-1:0];
						req_end_q    <= in_sum[BLOCK_BITS-1:0];
						res_where_q  <= '0;
						cnt_q        <= '0;
						unique case (in_mode)
							bfea_pkg::MODE_ALLOC: begin
								res_status_q <= bfea_pkg::ST_OK;
								state_q      <= S_SCAN;
							end
							bfea_pkg::MODE_FREE: begin
								if (in_ovf) begin
									res_status_q <= bfea_pkg::ST_OVERFLOW;
									state_q      <= S_RESULT;
								end else begin
									res_status_q <= bfea_pkg::ST_OK;
									state_q      <= S_SCAN;
								end
							end
							bfea_pkg::MODE_RESTART: begin
								res_status_q <= bfea_pkg::ST_OK;
								state_q      <= S_SWEEP;
							end
							default: begin
								res_status_q <= bfea_pkg::ST_OK;
								state_q      <= S_RESULT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					res_status_q <= dec_status;
					res_where_q  <= dec_where;
					state_q      <= dec_two ? S_WRITE2 : S_RESULT;
				end
				S_WRITE2: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					// Hold until the output register is free.
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_start_q  <= bfea_pkg::FIELD_W'(res_where_q);
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DRAIN) |-> !mem_we)
		else $error("extent memory written during a scan");

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("extent memory read and written in one cycle");

	a_read_data_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("read data returned outside a scan");

	a_result_from_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESULT))
		else $error("result loaded outside the result state");

endmodule

`default_nettype wire

### src/bfea_mem.sv
// Extent table memory: one write port, one registered read port.
`default_nettype none

module bfea_mem #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 65,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

`default_nettype wire

### src/bfea_scan.sv
// Scan unit: folds one table entry per cycle into best-fit and neighbor results.
`default_nettype none

module bfea_scan #(
	parameter int BLOCK_BITS = 32,
	parameter int IDX_W      = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bfea_pkg::scan_ctl_t   ctl,
	input  wire logic                  ent_valid,
	input  wire logic [BLOCK_BITS-1:0] ent_start,
	input  wire logic [BLOCK_BITS-1:0] ent_end,
	input  wire logic [IDX_W-1:0]      ent_idx,
	input  wire logic [BLOCK_BITS-1:0] req_start,
	input  wire logic [BLOCK_BITS-1:0] req_end,
	input  wire logic [BLOCK_BITS-1:0] req_count,
	output bfea_pkg::scan_flags_t      flags,
	output logic      [IDX_W-1:0]      best_idx,
	output logic      [BLOCK_BITS-1:0] best_start,
	output logic      [BLOCK_BITS-1:0] best_end,
	output logic      [IDX_W-1:0]      left_idx,
	output logic      [BLOCK_BITS-1:0] left_start,
	output logic      [IDX_W-1:0]      right_idx,
	output logic      [BLOCK_BITS-1:0] right_end,
	output logic      [IDX_W-1:0]      slot_idx
);

	bfea_pkg::scan_flags_t flags_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [BLOCK_BITS-1:0] best_start_q;
	logic [BLOCK_BITS-1:0] best_end_q;
	logic [BLOCK_BITS-1:0] best_span_q;
	logic [IDX_W-1:0]      left_idx_q;
	logic [BLOCK_BITS-1:0] left_start_q;
	logic [IDX_W-1:0]      right_idx_q;
	logic [BLOCK_BITS-1:0] right_end_q;
	logic [IDX_W-1:0]      slot_idx_q;

	logic [BLOCK_BITS-1:0] span;
	logic                  take_best;
	logic                  hit_ovl;
	logic                  hit_left;
	logic                  hit_right;
	logic                  take_slot;

	always_comb begin
		span      = ent_end - ent_start;
		// Smaller span wins; equal spans go to the lower start.
		take_best = ctl.en && !ctl.is_free && ent_valid && (span >= req_count) &&
			(!flags_q.best || (span < best_span_q) ||
			 ((span == best_span_q) && (ent_start < best_start_q)));
		hit_ovl   = ctl.en && ctl.is_free && ent_valid &&
			(req_end > ent_start) && (req_start < ent_end);
		hit_left  = ctl.en && ctl.is_free && ent_valid && (ent_end == req_start);
		hit_right = ctl.en && ctl.is_free && ent_valid && (ent_start == req_end);
		take_slot = ctl.en && ctl.is_free && !ent_valid && !flags_q.slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (ctl.clr) begin
			flags_q <= '0;
		end else begin
			if (take_best) flags_q.best    <= 1'b1;
			if (hit_ovl)   flags_q.overlap <= 1'b1;
			if (hit_left)  flags_q.left    <= 1'b1;
			if (hit_right) flags_q.right   <= 1'b1;
			if (take_slot) flags_q.slot    <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_best) begin
			best_idx_q   <= ent_idx;
			best_start_q <= ent_start;
			best_end_q   <= ent_end;
			best_span_q  <= span;
		end
		if (hit_left) begin
			left_idx_q   <= ent_idx;
			left_start_q <= ent_start;
		end
		if (hit_right) begin
			right_idx_q <= ent_idx;
			right_end_q <= ent_end;
		end
		if (take_slot) begin
			slot_idx_q <= ent_idx;
		end
	end

	assign flags      = flags_q;
	assign best_idx   = best_idx_q;
	assign best_start = best_start_q;
	assign best_end   = best_end_q;
	assign left_idx   = left_idx_q;
	assign left_start = left_start_q;
	assign right_idx  = right_idx_q;
	assign right_end  = right_end_q;
	assign slot_idx   = slot_idx_q;

endmodule

`default_nettype wire

### test/tb_best_fit_extent_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the best-fit extent allocator with a built-in table predictor.

module tb_best_fit_extent_allocator;

	localparam int SLOTS = 64;
	localparam logic [bfea_pkg::FIELD_W-1:0] TOP = {bfea_pkg::FIELD_W{1'b1}};

	typedef struct {
		bfea_pkg::mode_t              mode;
		logic [bfea_pkg::FIELD_W-1:0] start_block;
		logic [bfea_pkg::FIELD_W-1:0] block_count;
	} request_t;

	typedef struct {
		logic [bfea_pkg::FIELD_W-1:0] alloc_start;
		bfea_pkg::status_t            status;
	} grant_t;

	typedef struct {
		logic [bfea_pkg::FIELD_W-1:0] lo;
		logic [bfea_pkg::FIELD_W-1:0] n;
	} range_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	bfea_pkg::cfg_reg_t cfg_index;
	logic [bfea_pkg::FIELD_W-1:0] cfg_data;

	bfea_in_if  req_ch();
	bfea_out_if rsp_ch();

	best_fit_extent_allocator #(
		.MAX_EXTENTS(SLOTS),
		.BLOCK_BITS (bfea_pkg::FIELD_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (req_ch),
		.out_ch   (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predicted free table and region registers
	logic [bfea_pkg::FIELD_W-1:0] free_lo [SLOTS];
	logic [bfea_pkg::FIELD_W-1:0] free_hi [SLOTS];
	bit                           free_ok [SLOTS];
	logic [bfea_pkg::FIELD_W-1:0] region_lo = '0;
	logic [bfea_pkg::FIELD_W-1:0] region_hi = '0;

	request_t requests_q[$];
	grant_t   grants_due[$];
	range_t   held[$];

	int mismatches = 0;
	int max_gap = 11;
	int max_stall = 11;
	int by_mode[4];
	int by_status[5];

	function automatic grant_t compute_grant(request_t r);
		grant_t g;
		int pick, left, right, slot;
		logic [bfea_pkg::FIELD_W-1:0] span, pick_span;
		logic [bfea_pkg::FIELD_W:0] stop;
		bit clash;
		g.alloc_start = '0;
		g.status = bfea_pkg::ST_OK;
		pick = -1;
		left = -1;
		right = -1;
		slot = -1;
		pick_span = '0;
		clash = 1'b0;
		stop = {1'b0, r.start_block} + r.block_count;
		case (r.mode)
			bfea_pkg::MODE_ALLOC: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (free_ok[i]) begin
						span = free_hi[i] - free_lo[i];
						if (span >= r.block_count && (pick < 0 || span < pick_span ||
								(span == pick_span && free_lo[i] < free_lo[pick]))) begin
							pick = i;
							pick_span = span;
						end
					end
				end
				if (pick < 0) begin
					g.status = bfea_pkg::ST_OOM;
				end else begin
					g.alloc_start = free_lo[pick];
					free_lo[pick] += r.block_count;
					if (free_lo[pick] == free_hi[pick])
						free_ok[pick] = 1'b0;
					if (r.block_count != 0)
						held.push_back('{lo: g.alloc_start, n: r.block_count});
				end
			end
			bfea_pkg::MODE_FREE: begin
				if (stop[bfea_pkg::FIELD_W]) begin
					g.status = bfea_pkg::ST_OVERFLOW;
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (free_ok[i] && stop[bfea_pkg::FIELD_W-1:0] > free_lo[i] &&
								r.start_block < free_hi[i])
							clash = 1'b1;
					if (clash) begin
						g.status = bfea_pkg::ST_OVERLAP;
					end else if (r.block_count != 0) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (!free_ok[i]) begin
								if (slot < 0)
									slot = i;
							end else begin
								if (free_hi[i] == r.start_block)
									left = i;
								if (free_lo[i] == stop[bfea_pkg::FIELD_W-1:0])
									right = i;
							end
						end
						if (left >= 0 && right >= 0) begin
							free_hi[left] = free_hi[right];
							free_ok[right] = 1'b0;
						end else if (left >= 0) begin
							free_hi[left] = stop[bfea_pkg::FIELD_W-1:0];
						end else if (right >= 0) begin
							free_lo[right] = r.start_block;
						end else if (slot < 0) begin
							g.status = bfea_pkg::ST_FULL;
						end else begin
							free_lo[slot] = r.start_block;
							free_hi[slot] = stop[bfea_pkg::FIELD_W-1:0];
							free_ok[slot] = 1'b1;
						end
					end
				end
			end
			bfea_pkg::MODE_RESTART: begin
				for (int i = 0; i < SLOTS; i++)
					free_ok[i] = 1'b0;
				held.delete();
				if (region_hi > region_lo) begin
					free_lo[0] = region_lo;
					free_hi[0] = region_hi;
					free_ok[0] = 1'b1;
				end
			end
			default: begin
			end
		endcase
		by_mode[r.mode]++;
		by_status[g.status]++;
		return g;
	endfunction

	function automatic request_t req_of(bfea_pkg::mode_t m, logic [bfea_pkg::FIELD_W-1:0] s,
			logic [bfea_pkg::FIELD_W-1:0] c);
		request_t r;
		r.mode = m;
		r.start_block = s;
		r.block_count = c;
		return r;
	endfunction

	// Driver: hold an item until taken, then wait out a drawn gap before the next
	request_t on_bus;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.mode <= bfea_pkg::MODE_NOP;
			req_ch.start_block <= '0;
			req_ch.block_count <= '0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				grants_due.push_back(compute_grant(on_bus));
				gap_left = $urandom_range(0, max_gap);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (requests_q.size() > 0) begin
					on_bus = requests_q.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.mode <= on_bus.mode;
					req_ch.start_block <= on_bus.start_block;
					req_ch.block_count <= on_bus.block_count;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result with the oldest prediction
	grant_t want;
	int stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (grants_due.size() == 0) begin
					$error("result with nothing pending: alloc_start %h status %0d",
						rsp_ch.alloc_start, rsp_ch.status);
					mismatches++;
				end else begin
					want = grants_due.pop_front();
					if (rsp_ch.alloc_start !== want.alloc_start) begin
						$error("alloc_start: expected %h, got %h", want.alloc_start,
							rsp_ch.alloc_start);
						mismatches++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d (%s), got %0d", want.status,
							want.status.name(), rsp_ch.status);
						mismatches++;
					end
				end
				stall_left = $urandom_range(0, max_stall);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic issue(request_t r);
		@(negedge clk);
		while (requests_q.size() >= 2)
			@(negedge clk);
		requests_q.push_back(r);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (requests_q.size() != 0 || req_ch.valid || grants_due.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_region(logic [bfea_pkg::FIELD_W-1:0] lo,
			logic [bfea_pkg::FIELD_W-1:0] hi);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= bfea_pkg::REG_REGION_START;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= bfea_pkg::REG_REGION_END;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		region_lo = lo;
		region_hi = hi;
	endtask

	initial begin
		logic [bfea_pkg::FIELD_W-1:0] lo, hi, span, reach, base, k, fb;
		range_t h;
		int idx, pct, sub;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bfea_pkg::REG_REGION_START;
		cfg_data = '0;
		for (int i = 0; i < SLOTS; i++)
			free_ok[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, range overflow, overlap, merges, best fit and ties
		set_region(32'd100, 32'd1100);
		issue(req_of(bfea_pkg::MODE_NOP, TOP, TOP));
		issue(req_of(bfea_pkg::MODE_ALLOC, 32'd0, 32'd0));
		issue(req_of(bfea_pkg::MODE_FREE, TOP, 32'd1));
		issue(req_of(bfea_pkg::MODE_FREE, 32'hFFFF_FFF0, 32'hF));
		issue(req_of(bfea_pkg::MODE_FREE, 32'hFFFF_FFF0, 32'h20));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd0, TOP));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd5, 32'd0));
		issue(req_of(bfea_pkg::MODE_ALLOC, 32'd0, TOP));
		issue(req_of(bfea_pkg::MODE_RESTART, 32'd0, 32'd0));
		issue(req_of(bfea_pkg::MODE_ALLOC, TOP, 32'd0));
		issue(req_of(bfea_pkg::MODE_ALLOC, 32'd0, 32'd1001));
		issue(req_of(bfea_pkg::MODE_ALLOC, 32'd0, 32'd1000));
		issue(req_of(bfea_pkg::MODE_ALLOC, 32'd0, 32'd1));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd100, 32'd10));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd120, 32'd10));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd110, 32'd10));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd130, 32'd5));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd95, 32'd5));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd96, 32'd2));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd300, 32'd10));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd200, 32'd10));
		issue(req_of(bfea_pkg::MODE_FREE, 32'd150, 32'd20));
		issue(req_of(bfea_pkg::MODE_ALLOC, 32'd0, 32'd10));
		issue(req_of(bfea_pkg::MODE_ALLOC, 32'd0, 32'd5));
		issue(req_of(bfea_pkg::MODE_ALLOC, 32'd0, 32'd0));

		// Fill every slot with isolated ranges, overflow the table, then merge into it
		fb = $urandom_range(0, 32'hFFFF_0000);
		set_region(fb, fb);
		max_gap = 0;
		max_stall = 0;
		issue(req_of(bfea_pkg::MODE_RESTART, $urandom(), $urandom()));
		for (int i = 0; i <= SLOTS; i++)
			issue(req_of(bfea_pkg::MODE_FREE, fb + 2 * i, 32'd1));
		issue(req_of(bfea_pkg::MODE_FREE, fb + 1, 32'd1));
		issue(req_of(bfea_pkg::MODE_FREE, fb + 500, 32'd3));
		issue(req_of(bfea_pkg::MODE_ALLOC, $urandom(), 32'd3));

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					lo = '0;
					hi = TOP;
				end
				1: begin
					lo = TOP;
					hi = '0;
				end
				2: begin
					lo = TOP - 32'd1000;
					hi = TOP;
				end
				default: begin
					span = $urandom_range(16, 2048);
					lo = $urandom_range(0, TOP - span);
					hi = lo + span;
				end
			endcase
			set_region(lo, hi);
			span = (hi > lo) ? hi - lo : '0;
			reach = (span > 4096) ? 32'd4096 : span;
			base = (hi > lo) ? lo : $urandom_range(0, 32'hFFFF_0000);
			max_gap = (ph % 3 == 2) ? 0 : 11;
			max_stall = (ph % 3 == 2) ? 0 : 11;
			issue(req_of(bfea_pkg::MODE_RESTART, $urandom(), $urandom()));
			for (int n = 0; n < 120; n++) begin
				// pause the sender halfway until every result is back
				if (n == 60)
					wait_idle();
				pct = $urandom_range(0, 99);
				if (pct < 45) begin
					sub = $urandom_range(0, 9);
					if (sub < 7)
						k = $urandom_range(1, 64);
					else if (sub == 7)
						k = '0;
					else if (sub == 8)
						k = $urandom_range(1, span);
					else
						k = $urandom();
					issue(req_of(bfea_pkg::MODE_ALLOC, $urandom(), k));
				end else if (pct < 80 && held.size() > 0) begin
					idx = $urandom_range(0, held.size() - 1);
					h = held[idx];
					held.delete(idx);
					sub = $urandom_range(0, 3);
					k = (sub < 2) ? h.n : $urandom_range(1, h.n);
					if (sub == 3) begin
						// free the tail, keep the head
						issue(req_of(bfea_pkg::MODE_FREE, h.lo + h.n - k, k));
						if (k != h.n)
							held.push_back('{lo: h.lo, n: h.n - k});
					end else begin
						issue(req_of(bfea_pkg::MODE_FREE, h.lo, k));
						if (k != h.n)
							held.push_back('{lo: h.lo + k, n: h.n - k});
					end
				end else begin
					sub = $urandom_range(0, 9);
					case (sub)
						5: issue(req_of(bfea_pkg::MODE_FREE, $urandom(), $urandom()));
						6: issue(req_of(bfea_pkg::MODE_FREE, TOP - $urandom_range(0, 40),
							$urandom_range(0, 64)));
						7: issue(req_of(bfea_pkg::MODE_NOP, $urandom(), $urandom()));
						8: issue(req_of(bfea_pkg::MODE_ALLOC, $urandom(), $urandom()));
						9: issue(req_of(bfea_pkg::MODE_RESTART, $urandom(), $urandom()));
						default: issue(req_of(bfea_pkg::MODE_FREE,
							base + $urandom_range(0, reach + 64), $urandom_range(0, 32)));
					endcase
				end
			end
		end

		wait_idle();
		repeat (SLOTS + 8) @(posedge clk);
		$display("Requests: %0d allocate, %0d free, %0d restart, %0d unused mode",
			by_mode[bfea_pkg::MODE_ALLOC], by_mode[bfea_pkg::MODE_FREE],
			by_mode[bfea_pkg::MODE_RESTART], by_mode[bfea_pkg::MODE_NOP]);
		$display("Outcomes: %0d ok, %0d out of memory, %0d overlap, %0d table full, %0d overflow",
			by_status[bfea_pkg::ST_OK], by_status[bfea_pkg::ST_OOM],
			by_status[bfea_pkg::ST_OVERLAP], by_status[bfea_pkg::ST_FULL],
			by_status[bfea_pkg::ST_OVERFLOW]);
		if (mismatches == 0 && grants_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout: %0d results still pending", grants_due.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
src/bfea_pkg.sv
src/bfea_if.sv
src/bfea_mem.sv
src/bfea_scan.sv
src/best_fit_extent_allocator.sv
test/tb_best_fit_extent_allocator.sv
